// ===== sv/sld_pkg.sv =====
`default_nettype none

package sld_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 16;
	localparam int unsigned SyncW  = 32;
	localparam int unsigned PhaseW = 3;

	localparam logic [SyncW-1:0] SYNC_WORD_RST = 32'h7379_6E63;

	localparam logic [PhaseW-1:0] PH_SYNC0 = 3'd0;
	localparam logic [PhaseW-1:0] PH_SYNC1 = 3'd1;
	localparam logic [PhaseW-1:0] PH_SYNC2 = 3'd2;
	localparam logic [PhaseW-1:0] PH_SYNC3 = 3'd3;
	localparam logic [PhaseW-1:0] PH_LENHI = 3'd4;
	localparam logic [PhaseW-1:0] PH_LENLO = 3'd5;
	localparam logic [PhaseW-1:0] PH_DATA  = 3'd6;

	typedef struct packed {
		logic [ByteW-1:0] payload_byte;
		logic [LenW-1:0]  byte_index;
		logic             last;
	} result_t;

	// first sync byte sits in the top bits
	function automatic logic [ByteW-1:0] sync_byte(
		input logic [SyncW-1:0] word,
		input logic [1:0]       k
	);
		logic [ByteW-1:0] b;
		case (k)
			2'd0:    b = word[31:24];
			2'd1:    b = word[23:16];
			2'd2:    b = word[15:8];
			default: b = word[7:0];
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== sv/sld_fsm.sv =====
`default_nettype none

module sld_fsm (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [sld_pkg::SyncW-1:0] sync_word,
	input  wire logic [sld_pkg::ByteW-1:0] rx_byte,
	input  wire logic                      step,
	output logic                           res_valid,
	output sld_pkg::result_t               res
);
	import sld_pkg::*;

	logic [PhaseW-1:0] phase_q, phase_d;
	logic [LenW-1:0]   remain_q, remain_d;
	logic [LenW-1:0]   count_q, count_d;
	logic [LenW-1:0]   len_full;

	assign len_full = {remain_q[LenW-1:ByteW], rx_byte};

	always_comb begin
		phase_d   = phase_q;
		remain_d  = remain_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res.payload_byte = rx_byte;
		res.byte_index   = count_q;
		res.last         = (remain_q == LenW'(1));
		unique case (phase_q) inside
			PH_SYNC0: begin
				if (rx_byte == sync_byte(sync_word, 2'd0))
					phase_d = PH_SYNC1;
			end
			PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
				// a match on this position wins over a restart
				if (rx_byte == sync_byte(sync_word, phase_q[1:0]))
					phase_d = phase_q + PhaseW'(1);
				else if (rx_byte == sync_byte(sync_word, 2'd0))
					phase_d = PH_SYNC1;
				else
					phase_d = PH_SYNC0;
			end
			PH_LENHI: begin
				remain_d = {rx_byte, {ByteW{1'b0}}};
				phase_d  = PH_LENLO;
			end
			PH_LENLO: begin
				remain_d = len_full;
				count_d  = '0;
				phase_d  = (len_full != '0) ? PH_DATA : PH_SYNC0;
			end
			PH_DATA: begin
				if (remain_q == '0) begin
					phase_d = PH_SYNC0;
				end else begin
					res_valid = 1'b1;
					remain_d  = remain_q - LenW'(1);
					count_d   = count_q + LenW'(1);
					if (remain_q == LenW'(1))
						phase_d = PH_SYNC0;
				end
			end
			default: begin
				phase_d = PH_SYNC0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC0;
			remain_q <= '0;
			count_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			count_q  <= count_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/sld_out_reg.sv =====
`default_nettype none

module sld_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire sld_pkg::result_t res,
	output logic                  free,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output sld_pkg::result_t      out_res
);
	import sld_pkg::*;

	logic    valid_q;
	result_t res_q;

	// slot frees up in the same cycle its content is taken
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule

`default_nettype wire

// ===== sv/sync_length_deframer.sv =====
// Sync-word, length-prefixed deframer. Takes one received byte per transfer, hunts for
// the four sync bytes in cfg_data (first byte in bits 31:24, "sync" after reset), reads a
// big-endian 16-bit length and streams that many payload bytes out with their index and a
// last flag; zero-length frames give no output. One byte is taken every cycle unless the
// input stalls; a payload byte passes through the input register, then the output register,
// before it is offered on the output. The input stalls only while a result sits in the
// output register that is not being taken. Write cfg_data with cfg_we only while no byte is
// in flight; the new word applies from the next byte compared, and a frame already started
// carries on.
`default_nettype none

module sync_length_deframer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [sld_pkg::SyncW-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [sld_pkg::ByteW-1:0] rx_byte,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [sld_pkg::ByteW-1:0]      payload_byte,
	output logic [sld_pkg::LenW-1:0]       byte_index,
	output logic                           last
);
	import sld_pkg::*;

	logic [SyncW-1:0] sync_word_q;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             res_valid;
	logic             out_free;
	logic             advance;
	result_t          res;
	result_t          out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sync_word_q <= SYNC_WORD_RST;
		else if (cfg_we)
			sync_word_q <= cfg_data;
	end

	// byte in stage 1 moves on unless its result finds the output slot full
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	sld_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.sync_word (sync_word_q),
		.rx_byte   (byte_s1),
		.step      (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	sld_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.free      (out_free),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign payload_byte = out_res.payload_byte;
	assign byte_index   = out_res.byte_index;
	assign last         = out_res.last;

endmodule

`default_nettype wire

// ===== sv/sld_checker.sv =====
`default_nettype none

module sld_port_checks (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [sld_pkg::ByteW-1:0] payload_byte,
	input wire logic [sld_pkg::LenW-1:0]  byte_index,
	input wire logic                      last
);

	// input only backs up behind an output transfer that is not happening
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(byte_index) && $stable(last))
		else $error("output changed while stalled");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_index != 16'hFFFF)
		else $error("byte index out of range");

	a_max_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_index == 16'hFFFE |-> last)
		else $error("largest index not flagged last");

endmodule

bind sync_length_deframer sld_port_checks u_sld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.payload_byte (payload_byte),
	.byte_index   (byte_index),
	.last         (last)
);

`default_nettype wire

// ===== tb/sv/sld_checker.sv =====
`default_nettype none

module sld_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [sld_pkg::SyncW-1:0]  cfg_data,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire logic [sld_pkg::ByteW-1:0]  rx_byte,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire logic [sld_pkg::ByteW-1:0]  payload_byte,
	input  wire logic [sld_pkg::LenW-1:0]   byte_index,
	input  wire logic                       last,
	output int                              mismatch_count,
	output int                              outstanding,
	output int                              checked_count,
	output logic [sld_pkg::PhaseW-1:0]      frame_phase
);
	import sld_pkg::*;

	logic [SyncW-1:0]  sync_q      = SYNC_WORD_RST;
	logic [PhaseW-1:0] phase_q     = PH_SYNC0;
	logic [LenW-1:0]   remaining_q = '0;
	logic [LenW-1:0]   index_q     = '0;
	result_t           expected_payload[$];
	int                errors      = 0;
	int                seen        = 0;

	function automatic logic [ByteW-1:0] word_byte(input logic [1:0] k);
		return sync_q[8*(3-k) +: 8];
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			sync_q      = SYNC_WORD_RST;
			phase_q     = PH_SYNC0;
			remaining_q = '0;
			index_q     = '0;
			expected_payload.delete();
		end else begin
			if (cfg_we)
				sync_q = cfg_data;

			if (in_valid && in_ready) begin
				case (phase_q)
					PH_SYNC0: begin
						if (rx_byte == word_byte(2'd0))
							phase_q = PH_SYNC1;
					end
					PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
						// a match on the current position wins over a restart
						if (rx_byte == word_byte(phase_q[1:0]))
							phase_q = phase_q + 1'b1;
						else if (rx_byte == word_byte(2'd0))
							phase_q = PH_SYNC1;
						else
							phase_q = PH_SYNC0;
					end
					PH_LENHI: begin
						remaining_q = {rx_byte, 8'h00};
						phase_q     = PH_LENLO;
					end
					PH_LENLO: begin
						remaining_q = {remaining_q[15:8], rx_byte};
						index_q     = '0;
						phase_q     = (remaining_q != '0) ? PH_DATA : PH_SYNC0;
					end
					PH_DATA: begin
						if (remaining_q == '0) begin
							phase_q = PH_SYNC0;
						end else begin
							remaining_q = remaining_q - 1'b1;
							want.payload_byte = rx_byte;
							want.byte_index   = index_q;
							want.last         = (remaining_q == '0);
							expected_payload.push_back(want);
							index_q = index_q + 1'b1;
							if (remaining_q == '0)
								phase_q = PH_SYNC0;
						end
					end
					default: phase_q = PH_SYNC0;
				endcase
			end

			if (out_valid && out_ready) begin
				if (expected_payload.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected payload byte %02h index %0d last %0b",
							$time, payload_byte, byte_index, last);
					errors++;
				end else begin
					want = expected_payload.pop_front();
					seen++;
					if (payload_byte !== want.payload_byte || byte_index !== want.byte_index ||
							last !== want.last) begin
						if (errors < 10)
							$display({"%0t: mismatch, expected byte %02h index %0d last %0b,",
								" got byte %02h index %0d last %0b"}, $time,
								want.payload_byte, want.byte_index, want.last,
								payload_byte, byte_index, last);
						errors++;
					end
				end
			end
		end
		mismatch_count <= errors;
		outstanding    <= expected_payload.size();
		checked_count  <= seen;
		frame_phase    <= phase_q;
	end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
	import sld_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE      = 6;
	localparam int SEG_ITEMS   = 270;
	localparam int N_SEG       = 6;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [SyncW-1:0]  cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic [ByteW-1:0]  rx_byte   = '0;
	logic              out_ready = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic [ByteW-1:0]  payload_byte;
	logic [LenW-1:0]   byte_index;
	logic              last;

	int                mismatches;
	int                waiting;
	int                checked;
	logic [PhaseW-1:0] hunt_phase;

	int                idle_pct  = 0;
	int                stall_pct = 0;
	int                sent      = 0;
	int                words     = 0;
	int                quiet     = 0;
	logic [SyncW-1:0]  cur_word  = SYNC_WORD_RST;

	int seg_idle[N_SEG]  = '{0, 80, 0, 33, 33, 0};
	int seg_stall[N_SEG] = '{0, 0, 80, 33, 33, 0};

	sync_length_deframer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.last         (last)
	);

	sld_checker frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.last           (last),
		.mismatch_count (mismatches),
		.outstanding    (waiting),
		.checked_count  (checked),
		.frame_phase    (hunt_phase)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic logic [ByteW-1:0] sync_char(input int k);
		return cur_word[8*(3-k) +: 8];
	endfunction

	task automatic send_byte(input logic [ByteW-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_header(input logic [LenW-1:0] len);
		for (int k = 0; k < 4; k++)
			send_byte(sync_char(k));
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	task automatic send_frame(input logic [LenW-1:0] len, input int body);
		send_header(len);
		repeat (body) send_byte(ByteW'($urandom_range(255)));
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// feed filler until the deframer is back in the hunt, then let it drain
	task automatic return_to_hunt();
		logic [ByteW-1:0] fill;
		quiesce();
		fill = (sync_char(0) == 8'h00) ? 8'h01 : 8'h00;
		while (hunt_phase != PH_SYNC0)
			send_byte(fill);
		quiesce();
	endtask

	task automatic write_sync(input logic [SyncW-1:0] w);
		return_to_hunt();
		cfg_we   <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_word = w;
		words++;
	endtask

	task automatic random_traffic(input int n_items);
		int start;
		int kind;
		int len;
		int k;
		start = sent;
		while (sent - start < n_items) begin
			kind = $urandom_range(99);
			if (kind < 75) begin
				k = $urandom_range(99);
				if (k < 10)
					len = 0;
				else if (k < 90)
					len = $urandom_range(1, 12);
				else if (k < 99)
					len = $urandom_range(13, 100);
				else
					len = $urandom_range(101, 600);
				send_frame(LenW'(len), len);
			end else if (kind < 85) begin
				// cut short: the next frame's bytes get eaten as payload
				len = $urandom_range(1, 12);
				send_frame(LenW'(len), $urandom_range(0, len - 1));
			end else if (kind < 93) begin
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++)
					send_byte(sync_char(i));
				if ($urandom_range(1))
					send_byte(sync_char(0));
				else
					send_byte(ByteW'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [SyncW-1:0] w;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length, a one-byte frame, then a two-byte frame with extreme payload values
		send_frame(16'd0, 0);
		send_frame(16'd1, 1);
		send_header(16'd2);
		send_byte(8'h00);
		send_byte(8'hFF);
		// first sync byte inside the word restarts at the second position
		send_byte(sync_char(0));
		send_byte(sync_char(1));
		send_header(16'd1);
		send_byte(8'hA5);
		// any other mismatch drops back to the hunt
		send_byte(sync_char(0));
		send_byte(sync_char(1));
		send_byte(8'h00);
		send_byte(sync_char(2));
		send_byte(sync_char(3));
		// nonzero high length byte, index runs past eight bits
		send_frame(16'h0102, 258);
		random_traffic(SEG_ITEMS);

		for (int s = 1; s < N_SEG; s++) begin
			case (s)
				1:       w = 32'h0000_0000;
				2:       w = 32'hFFFF_FFFF;
				3:       w = 32'h4141_4142;
				4:       w = $urandom();
				default: w = SYNC_WORD_RST;
			endcase
			write_sync(w);
			idle_pct  = seg_idle[s];
			stall_pct = seg_stall[s];
			random_traffic(SEG_ITEMS);
		end
		quiesce();

		$display("run: %0d bytes in, %0d payload bytes checked, %0d sync word writes",
			sent, checked, words);
		$display("run: idle mixes none, sender, receiver and both; sync words incl. all-0/all-1");
		if (mismatches == 0 && waiting == 0) begin
			$display("testbench: PASS");
		end else begin
			if (waiting != 0)
				$display("%0d expected payload bytes never came out", waiting);
			$display("%0d mismatches", mismatches);
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
